// ----- hdl/pru_pkg.sv -----
// Shared types, codes and constants of the pixel replication upscaler.
`timescale 1ns / 1ps

package pru_pkg;

	localparam int DEF_MAX_WIDTH = 1024;
	localparam int SCALE_W       = 5;
	localparam int SRC_WIDTH_W   = 11;
	localparam int CFG_DATA_W    = 11;
	localparam int REP_W         = 5;
	localparam int PAD_W         = 2;
	localparam int MAX_SCALE     = 16;

	typedef enum logic [0:0] {
		CMD_PIXEL  = 1'b0,
		CMD_REPLAY = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_PIXEL  = 2'd0,
		KIND_PAD    = 2'd1,
		KIND_REJECT = 2'd2
	} kind_t;

	typedef enum logic [0:0] {
		REG_SCALE        = 1'b0,
		REG_SOURCE_WIDTH = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} pix_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [7:0] blue;
		logic [7:0] green;
		logic [7:0] red;
	} in_t;

	typedef struct packed {
		kind_t      kind;
		logic [7:0] out_blue;
		logic [7:0] out_green;
		logic [7:0] out_red;
		logic       row_end;
		logic       last;
	} out_t;

	typedef struct packed {
		logic               reject;
		logic               use_ram;
		pix_t               pix;
		logic [REP_W-1:0]   rep_cnt;
		logic [PAD_W-1:0]   pad_cnt;
		logic               rend;
	} job_t;

endpackage

// ----- hdl/pru_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module pru_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- hdl/pru_ctrl.sv -----
// Configuration registers, fill and replay bookkeeping, and line store access.
`timescale 1ns / 1ps

module pru_ctrl
	import pru_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH,
	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1,
	localparam int CW = $clog2(MAX_WIDTH + 1),
	localparam int WW = (CW > SRC_WIDTH_W) ? CW : SRC_WIDTH_W
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_we,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  take,
	input  in_t                   item,
	output job_t                  job,
	output logic                  ram_we,
	output logic [AW-1:0]         ram_waddr,
	output pix_t                  ram_wdata,
	output logic                  ram_re,
	output logic [AW-1:0]         ram_raddr
);

	logic [SCALE_W-1:0]     scale_q;
	logic [SRC_WIDTH_W-1:0] width_q;
	logic [AW-1:0]          fill_column_q;
	logic                   replay_pending_q;
	logic [3:0]             rows_left_q;
	logic [CW-1:0]          replay_column_q;
	logic [3:0]             repeat_count_q;
	logic [PAD_W-1:0]       pad_count_q;

	logic [SCALE_W-1:0] s_eff;
	logic [WW-1:0]      src_w;
	logic [CW-1:0]      w_eff;
	logic [3:0]         ws_low;
	logic [PAD_W-1:0]   pad;
	logic               row_done;
	logic [CW:0]        col_next;
	logic [SCALE_W-1:0] rep_next;
	logic [PAD_W:0]     pad_next;
	logic               replay_pix;
	logic               col_step;
	logic               finish;
	pix_t               in_pix;

	always_comb begin
		if (scale_q == '0) begin
			s_eff = SCALE_W'(1);
		end else if (scale_q > SCALE_W'(MAX_SCALE)) begin
			s_eff = SCALE_W'(MAX_SCALE);
		end else begin
			s_eff = scale_q;
		end
		src_w = WW'(width_q);
		if (src_w == '0) begin
			w_eff = CW'(1);
		end else if (src_w > WW'(MAX_WIDTH)) begin
			w_eff = CW'(MAX_WIDTH);
		end else begin
			w_eff = CW'(src_w);
		end
	end

	// The row length in bytes is w*s*3, so the pad count is (w*s) mod 4.
	assign ws_low = {2'b00, w_eff[1:0]} * {2'b00, s_eff[1:0]};
	assign pad    = ws_low[PAD_W-1:0];

	assign in_pix     = '{red: item.red, green: item.green, blue: item.blue};
	assign row_done   = ((CW + 1)'(fill_column_q) + (CW + 1)'(1)) >= (CW + 1)'(w_eff);
	assign replay_pix = replay_column_q < w_eff;
	assign rep_next   = SCALE_W'(repeat_count_q) + SCALE_W'(1);
	assign col_step   = rep_next >= s_eff;
	assign col_next   = (CW + 1)'(replay_column_q) + (CW + 1)'(1);
	assign pad_next   = (PAD_W + 1)'(pad_count_q) + (PAD_W + 1)'(1);

	always_comb begin
		job        = '0;
		finish     = 1'b0;
		if (item.cmd == CMD_PIXEL) begin
			if (replay_pending_q) begin
				job.reject = 1'b1;
			end else begin
				job.pix     = in_pix;
				job.rep_cnt = s_eff;
				job.pad_cnt = row_done ? pad : '0;
				job.rend    = row_done;
			end
		end else if (!replay_pending_q) begin
			job.reject = 1'b1;
		end else if (replay_pix) begin
			job.use_ram = 1'b1;
			job.rep_cnt = REP_W'(1);
			job.rend    = col_step && (col_next >= (CW + 1)'(w_eff)) && (pad == '0);
			finish      = job.rend;
		end else begin
			job.pad_cnt = PAD_W'(1);
			job.rend    = (pad == '0) || (pad_next >= (PAD_W + 1)'(pad));
			finish      = job.rend;
		end
	end

	assign ram_we    = take && (item.cmd == CMD_PIXEL) && !replay_pending_q;
	assign ram_waddr = fill_column_q;
	assign ram_wdata = in_pix;
	assign ram_re    = take && (item.cmd == CMD_REPLAY) && replay_pending_q && replay_pix;
	assign ram_raddr = replay_column_q[AW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scale_q <= SCALE_W'(1);
			width_q <= SRC_WIDTH_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SCALE: begin
					scale_q <= cfg_data[SCALE_W-1:0];
				end
				REG_SOURCE_WIDTH: begin
					width_q <= cfg_data[SRC_WIDTH_W-1:0];
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_column_q    <= '0;
			replay_pending_q <= 1'b0;
			rows_left_q      <= '0;
			replay_column_q  <= '0;
			repeat_count_q   <= '0;
			pad_count_q      <= '0;
		end else if (take) begin
			if (ram_we) begin
				if (row_done) begin
					fill_column_q <= '0;
					if (s_eff > SCALE_W'(1)) begin
						replay_pending_q <= 1'b1;
						rows_left_q      <= 4'(s_eff - SCALE_W'(1));
						replay_column_q  <= '0;
						repeat_count_q   <= '0;
						pad_count_q      <= '0;
					end
				end else begin
					fill_column_q <= fill_column_q + AW'(1);
				end
			end else if ((item.cmd == CMD_REPLAY) && replay_pending_q) begin
				if (finish) begin
					replay_column_q <= '0;
					repeat_count_q  <= '0;
					pad_count_q     <= '0;
					if (rows_left_q <= 4'd1) begin
						rows_left_q      <= '0;
						replay_pending_q <= 1'b0;
					end else begin
						rows_left_q <= rows_left_q - 4'd1;
					end
				end else if (replay_pix) begin
					if (col_step) begin
						repeat_count_q  <= '0;
						replay_column_q <= col_next[CW-1:0];
					end else begin
						repeat_count_q <= rep_next[3:0];
					end
				end else begin
					pad_count_q <= pad_next[PAD_W-1:0];
				end
			end
		end
	end

endmodule

// ----- hdl/pru_emit.sv -----
// Job register that expands one accepted item into its results, and the output register.
`timescale 1ns / 1ps

module pru_emit
	import pru_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic load,
	input  job_t job_in,
	input  pix_t ram_rdata,
	output logic job_ready,
	output logic result_valid,
	input  logic result_ready,
	output out_t result_data
);

	logic valid_s1;
	job_t job_s1;
	logic out_free;
	logic item_pix;
	logic item_final;
	logic advance;
	pix_t item_rgb;
	out_t item;

	assign out_free   = !result_valid || result_ready;
	assign advance    = valid_s1 && out_free;
	assign item_pix   = job_s1.rep_cnt != '0;
	assign item_final = item_pix ? ((job_s1.rep_cnt == REP_W'(1)) && (job_s1.pad_cnt == '0))
	                             : (job_s1.pad_cnt <= PAD_W'(1));
	assign job_ready  = !valid_s1 || (out_free && item_final);
	assign item_rgb   = job_s1.use_ram ? ram_rdata : job_s1.pix;

	always_comb begin
		item = '0;
		if (job_s1.reject) begin
			item.kind = KIND_REJECT;
		end else if (item_pix) begin
			item.kind      = KIND_PIXEL;
			item.out_blue  = item_rgb.blue;
			item.out_green = item_rgb.green;
			item.out_red   = item_rgb.red;
		end else begin
			item.kind = KIND_PAD;
		end
		item.row_end = item_final && job_s1.rend && !job_s1.reject;
		item.last    = item_final;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (advance && item_final) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			job_s1 <= job_in;
		end else if (advance) begin
			if (item_pix) begin
				job_s1.rep_cnt <= job_s1.rep_cnt - REP_W'(1);
			end else if (job_s1.pad_cnt != '0) begin
				job_s1.pad_cnt <= job_s1.pad_cnt - PAD_W'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else if (advance) begin
			result_valid <= 1'b1;
		end else if (result_ready) begin
			result_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			result_data <= item;
		end
	end

endmodule

// ----- hdl/pixel_replication_upscaler_unit.sv -----
// Pixel replication upscaler: an integer-factor nearest-neighbor enlarger for 24-bit pixels.
//
// Configuration writes arrive on the cfg channel (index 0 is the scale, index 1 the
// source width) and are always taken; they are meant to happen while the block is idle.
// The pixel channel carries source pixels and replay steps. A source pixel is written
// to the line store and gives scale output pixels, followed by the row pad bytes when
// it closes a source row. Each replay step gives exactly one output item, a pixel read
// back from the line store or, once the row's pixels are done, a pad byte. A pixel during
// pending replay, or a replay step with nothing pending, gives one rejection result.
// The first result of a transfer passes through the emit stage's job register and then the
// output register. A source pixel gives scale plus pad results (at most 18); a replay step
// or a rejection gives one result, so replay steps run at one per clock while the receiver
// keeps up. The next item is taken in the cycle in which the last result of the current
// one moves into the output register, which is set by the single emit stage. When the
// receiver stalls, the output register holds its result, the emit stage holds its item
// and, once that stage is full, the pixel channel stops accepting. Reset clears all counters
// and sets scale and source width to one; the line store holds no data until written.
`timescale 1ns / 1ps

module pixel_replication_upscaler_unit
	import pru_pkg::*;
#(
	parameter int MAX_WIDTH = DEF_MAX_WIDTH
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  reg_idx_t              cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	input  logic                  pixel_valid,
	output logic                  pixel_ready,
	input  in_t                   pixel_data,
	output logic                  result_valid,
	input  logic                  result_ready,
	output out_t                  result_data
);

	localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

	logic          take;
	job_t          job;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	pix_t          ram_wdata;
	logic          ram_re;
	logic [AW-1:0] ram_raddr;
	pix_t          ram_rdata;

	assign cfg_ready = 1'b1;
	assign take      = pixel_valid && pixel_ready;

	pru_ctrl #(
		.MAX_WIDTH(MAX_WIDTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.take      (take),
		.item      (pixel_data),
		.job       (job),
		.ram_we    (ram_we),
		.ram_waddr (ram_waddr),
		.ram_wdata (ram_wdata),
		.ram_re    (ram_re),
		.ram_raddr (ram_raddr)
	);

	pru_ram #(
		.WIDTH($bits(pix_t)),
		.DEPTH(MAX_WIDTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	pru_emit u_emit (
		.clk          (clk),
		.arst_n       (arst_n),
		.load         (take),
		.job_in       (job),
		.ram_rdata    (ram_rdata),
		.job_ready    (pixel_ready),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

endmodule

// ----- hdl/pru_checker.sv -----
// Port-level checks of the pixel replication upscaler and their binding to the top level.
`timescale 1ns / 1ps

module pru_checker
	import pru_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic result_valid,
	input logic result_ready,
	input out_t result_data
);

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_data))
		else $error("Stalled result changed or dropped.");

	a_row_end_last: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_data.row_end |-> result_data.last)
		else $error("Row end on a result that is not the last of its transfer.");

	a_zero_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.kind != KIND_PIXEL) |->
		(result_data.out_blue == 8'd0) && (result_data.out_green == 8'd0) &&
		(result_data.out_red == 8'd0))
		else $error("Pad or rejection carries pixel bytes.");

	a_reject_shape: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && (result_data.kind == KIND_REJECT) |->
		result_data.last && !result_data.row_end)
		else $error("Rejection is not a single result without row end.");

endmodule

bind pixel_replication_upscaler_unit pru_checker u_pru_checker (.*);

// ----- sim/tb_top.sv -----
// Self-checking testbench for the pixel replication upscaler unit.
`timescale 1ns / 1ps

module tb_top;
	import pru_pkg::*;

	localparam int HALF_PERIOD = 6;
	localparam int RESET_CYCLES = 10;
	localparam int HOLD_CYCLES = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT = 50000;
	localparam int MAX_REPORTS = 10;
	localparam int ROW_ITEMS = 300;
	localparam int TOTAL_ITEMS = 380;
	localparam longint RUN_LIMIT_NS = 5_000_000;

	typedef enum int {
		RDY_ALWAYS,
		RDY_HALF,
		RDY_SPARSE,
		RDY_PERIODIC
	} ready_mode_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	reg_idx_t              cfg_index = REG_SCALE;
	logic [CFG_DATA_W-1:0] cfg_data = '0;
	logic                  pixel_valid = 1'b0;
	logic                  pixel_ready;
	in_t                   pixel_data = '0;
	logic                  result_valid;
	logic                  result_ready = 1'b0;
	out_t                  result_data;

	// Mirror of the block state, updated on every accepted input transfer.
	logic [23:0]            row_pixels [DEF_MAX_WIDTH];
	bit                     row_pixel_set [DEF_MAX_WIDTH];
	int unsigned            fill_col = 0;
	int unsigned            rows_to_replay = 0;
	int unsigned            replay_col = 0;
	int unsigned            repeat_cnt = 0;
	int unsigned            pad_cnt = 0;
	bit                     replay_due = 1'b0;
	logic [SCALE_W-1:0]     scale_reg = SCALE_W'(1);
	logic [SRC_WIDTH_W-1:0] width_reg = SRC_WIDTH_W'(1);
	out_t                   replicated_due [$];

	int unsigned mismatch_count = 0;
	int unsigned items_sent = 0;
	int unsigned burst_left = 0;
	bit          steady_sender = 1'b0;
	logic        hold_active = 1'b0;
	event        hold_start;
	ready_mode_t ready_mode = RDY_ALWAYS;
	int unsigned ready_left = 0;

	pixel_replication_upscaler_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.pixel_valid  (pixel_valid),
		.pixel_ready  (pixel_ready),
		.pixel_data   (pixel_data),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result_data  (result_data)
	);

	always begin
		#HALF_PERIOD clk = 1'b1;
		#HALF_PERIOD clk = 1'b0;
	end

	function automatic int unsigned eff_scale();
		if (scale_reg == 0) return 1;
		if (scale_reg > MAX_SCALE) return MAX_SCALE;
		return scale_reg;
	endfunction

	function automatic int unsigned clamp_width(logic [SRC_WIDTH_W-1:0] w);
		if (w == 0) return 1;
		if (w > DEF_MAX_WIDTH) return DEF_MAX_WIDTH;
		return w;
	endfunction

	function automatic int unsigned pad_len(int unsigned s, int unsigned w);
		return (4 - ((w * s * 3) % 4)) % 4;
	endfunction

	function automatic bit width_is_safe(logic [SRC_WIDTH_W-1:0] w);
		int unsigned i;
		if (!replay_due) return 1'b1;
		for (i = 0; i < clamp_width(w); i++) begin
			if (!row_pixel_set[i]) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void push_result(kind_t kind, logic [23:0] pix, bit rend, bit fin);
		out_t r;
		r.kind = kind;
		r.out_blue = pix[7:0];
		r.out_green = pix[15:8];
		r.out_red = pix[23:16];
		r.row_end = rend;
		r.last = fin;
		replicated_due.push_back(r);
	endfunction

	function automatic void close_replay_row();
		replay_col = 0;
		repeat_cnt = 0;
		pad_cnt = 0;
		if (rows_to_replay > 0) rows_to_replay--;
		if (rows_to_replay == 0) replay_due = 1'b0;
	endfunction

	function automatic void replicate_item(in_t item);
		int unsigned s;
		int unsigned w;
		int unsigned pad;
		int unsigned i;
		bit          row_done;
		bit          rend;
		logic [23:0] pix;
		s = eff_scale();
		w = clamp_width(width_reg);
		pad = pad_len(s, w);
		if (item.cmd == CMD_PIXEL) begin
			if (replay_due) begin
				push_result(KIND_REJECT, '0, 1'b0, 1'b1);
				return;
			end
			pix = {item.red, item.green, item.blue};
			row_pixels[fill_col] = pix;
			row_pixel_set[fill_col] = 1'b1;
			row_done = (fill_col + 1 >= w);
			for (i = 0; i < s; i++) begin
				push_result(KIND_PIXEL, pix, (i + 1 == s) && row_done && pad == 0,
					(i + 1 == s) && (!row_done || pad == 0));
			end
			if (row_done) begin
				for (i = 0; i < pad; i++) push_result(KIND_PAD, '0, i + 1 == pad, i + 1 == pad);
				fill_col = 0;
				if (s > 1) begin
					replay_due = 1'b1;
					rows_to_replay = s - 1;
					replay_col = 0;
					repeat_cnt = 0;
					pad_cnt = 0;
				end
			end else begin
				fill_col++;
			end
		end else if (!replay_due) begin
			push_result(KIND_REJECT, '0, 1'b0, 1'b1);
		end else if (replay_col < w) begin
			pix = row_pixels[replay_col];
			rend = 1'b0;
			repeat_cnt++;
			if (repeat_cnt >= s) begin
				repeat_cnt = 0;
				replay_col++;
				rend = (replay_col >= w) && pad == 0;
			end
			push_result(KIND_PIXEL, pix, rend, 1'b1);
			if (rend) close_replay_row();
		end else if (pad == 0) begin
			// The width shrank under the replay, so the row closes with a single pad byte.
			push_result(KIND_PAD, '0, 1'b1, 1'b1);
			close_replay_row();
		end else begin
			pad_cnt++;
			push_result(KIND_PAD, '0, pad_cnt >= pad, 1'b1);
			if (pad_cnt >= pad) close_replay_row();
		end
	endfunction

	function automatic in_t make_item(cmd_t c, logic [23:0] bgr);
		in_t item;
		item.cmd = c;
		{item.blue, item.green, item.red} = bgr;
		return item;
	endfunction

	function automatic logic [23:0] any_bgr();
		return 24'($urandom_range(0, 24'hFFFFFF));
	endfunction

	task automatic send_item(in_t item);
		if (!steady_sender && burst_left == 0) begin
			pixel_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
			burst_left = $urandom_range(1, 40);
		end
		pixel_valid <= 1'b1;
		pixel_data <= item;
		@(posedge clk);
		while (!pixel_ready) @(posedge clk);
		replicate_item(item);
		items_sent++;
		if (burst_left > 0) burst_left--;
	endtask

	task automatic wait_idle();
		int unsigned n;
		pixel_valid <= 1'b0;
		n = 0;
		while (replicated_due.size() != 0 && n < DRAIN_LIMIT) begin
			@(posedge clk);
			n++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic load_config(int unsigned s, int unsigned w);
		wait_idle();
		cfg_valid <= 1'b1;
		cfg_index <= REG_SCALE;
		cfg_data <= CFG_DATA_W'(SCALE_W'(s));
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		scale_reg = SCALE_W'(s);
		cfg_index <= REG_SOURCE_WIDTH;
		cfg_data <= CFG_DATA_W'(SRC_WIDTH_W'(w));
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		width_reg = SRC_WIDTH_W'(w);
		cfg_valid <= 1'b0;
	endtask

	// A whole source row and all of its replay, with a stray item now and then.
	task automatic play_image_row();
		while (replay_due) send_item(make_item(CMD_REPLAY, any_bgr()));
		do begin
			send_item(make_item(CMD_PIXEL, any_bgr()));
			if ($urandom_range(0, 15) == 0) send_item(make_item(CMD_REPLAY, any_bgr()));
		end while (fill_col != 0);
		while (replay_due) begin
			send_item(make_item(CMD_REPLAY, any_bgr()));
			if ($urandom_range(0, 15) == 0) send_item(make_item(CMD_PIXEL, any_bgr()));
		end
	endtask

	task automatic test_corner_items();
		send_item(make_item(CMD_PIXEL, 24'hFFFFFF));
		send_item(make_item(CMD_REPLAY, 24'h000000));
		load_config(0, 0);
		send_item(make_item(CMD_PIXEL, 24'h000000));
		load_config(2, 2);
		send_item(make_item(CMD_PIXEL, 24'hFF0000));
		send_item(make_item(CMD_PIXEL, 24'h00FF00));
		send_item(make_item(CMD_PIXEL, 24'h0000FF));
		repeat (4) send_item(make_item(CMD_REPLAY, 24'hFFFFFF));
		send_item(make_item(CMD_REPLAY, 24'h5AA55A));
	endtask

	task automatic test_register_changes();
		// A narrower width closes the row being filled.
		load_config(31, 2047);
		send_item(make_item(CMD_PIXEL, any_bgr()));
		load_config(2, 1);
		send_item(make_item(CMD_PIXEL, any_bgr()));
		// A larger scale stretches the pending replay row.
		load_config(31, 1);
		while (replay_due) send_item(make_item(CMD_REPLAY, any_bgr()));
		send_item(make_item(CMD_REPLAY, any_bgr()));
		// A narrower width moves the replay straight into its pad phase.
		load_config(2, 3);
		repeat (3) send_item(make_item(CMD_PIXEL, any_bgr()));
		repeat (4) send_item(make_item(CMD_REPLAY, any_bgr()));
		load_config(2, 2);
		send_item(make_item(CMD_REPLAY, any_bgr()));
	endtask

	task automatic test_backpressure();
		load_config(4, 3);
		steady_sender = 1'b1;
		-> hold_start;
		play_image_row();
		steady_sender = 1'b0;
	endtask

	task automatic test_image_rows();
		int unsigned pick;
		int unsigned s;
		int unsigned w;
		while (items_sent < ROW_ITEMS) begin
			pick = $urandom_range(0, 9);
			if (pick < 7) begin
				s = $urandom_range(1, 3);
				w = $urandom_range(1, 5);
			end else if (pick < 9) begin
				s = $urandom_range(4, 6);
				w = 1;
			end else begin
				s = 1;
				w = $urandom_range(17, 40);
			end
			load_config(s, w);
			play_image_row();
		end
	endtask

	task automatic test_random_mix();
		logic [SRC_WIDTH_W-1:0] w;
		while (items_sent < TOTAL_ITEMS) begin
			if ($urandom_range(0, 19) == 0) begin
				w = ($urandom_range(0, 7) == 0) ? SRC_WIDTH_W'($urandom_range(0, 2047))
					: SRC_WIDTH_W'($urandom_range(0, 8));
				if (!width_is_safe(w)) w = width_reg;
				load_config($urandom_range(0, 31), w);
			end
			send_item(make_item(cmd_t'($urandom_range(0, 1)), any_bgr()));
		end
	endtask

	always @(posedge clk) begin
		if (ready_left == 0) begin
			ready_mode <= ready_mode_t'($urandom_range(0, 3));
			ready_left <= $urandom_range(16, 160);
		end else begin
			ready_left <= ready_left - 1;
		end
		case (ready_mode)
			RDY_ALWAYS: result_ready <= !hold_active;
			RDY_HALF: result_ready <= !hold_active && ($urandom_range(0, 1) == 1);
			RDY_SPARSE: result_ready <= !hold_active && ($urandom_range(0, 4) == 0);
			default: result_ready <= !hold_active && (ready_left % 3 != 0);
		endcase
	end

	initial begin : receiver_hold
		int unsigned n;
		forever begin
			@(hold_start);
			hold_active <= 1'b1;
			for (n = 0; n < HOLD_CYCLES; n++) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	always @(posedge clk) begin : result_check
		out_t want;
		if (arst_n && result_valid && result_ready) begin
			if (replicated_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MAX_REPORTS) begin
					$display("%0t: unexpected transfer: kind %0d bgr %02h %02h %02h row_end %0b last %0b",
						$time, result_data.kind, result_data.out_blue, result_data.out_green,
						result_data.out_red, result_data.row_end, result_data.last);
				end
			end else begin
				want = replicated_due.pop_front();
				if (result_data.kind !== want.kind || result_data.out_blue !== want.out_blue ||
					result_data.out_green !== want.out_green ||
					result_data.out_red !== want.out_red ||
					result_data.row_end !== want.row_end || result_data.last !== want.last) begin
					mismatch_count++;
					if (mismatch_count <= MAX_REPORTS) begin
						$display("%0t: expected kind %0d bgr %02h %02h %02h row_end %0b last %0b",
							$time, want.kind, want.out_blue, want.out_green, want.out_red,
							want.row_end, want.last);
						$display("%0t: actual   kind %0d bgr %02h %02h %02h row_end %0b last %0b",
							$time, result_data.kind, result_data.out_blue, result_data.out_green,
							result_data.out_red, result_data.row_end, result_data.last);
					end
				end
			end
		end
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("pixel_replication_upscaler_unit verification failed");
		$finish;
	end

	initial begin
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_corner_items();
		test_register_changes();
		test_backpressure();
		test_image_rows();
		test_random_mix();
		wait_idle();
		if (mismatch_count == 0 && replicated_due.size() == 0) begin
			$display("pixel_replication_upscaler_unit verification clean");
		end else begin
			$display("pixel_replication_upscaler_unit verification failed");
		end
		$finish;
	end

endmodule
